// ===== rtl/i2a_pkg.sv =====
package i2a_pkg;

    localparam int MAX_WIDTH_DEF = 48;

    localparam int VAL_W      = 32;
    localparam int FW_W       = 6;
    localparam int PREC_W     = 6;
    localparam int CMD_W      = 3;
    localparam int BCD_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LHEX = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UHEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIX  = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LOWER = 8'h20;

    localparam logic [127:0] DIGIT_TAB = "0123456789ABCDEF";

    typedef logic [BCD_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        logic       bad;
        logic       sign_en;
        logic       sign_first;
        logic [7:0] sign_ch;
        logic [7:0] fill_ch;
        logic       lower;
        logic [3:0] num_dig;
        logic       dot_en;
        logic [3:0] dot_pos;
        t_digits    digits;
    } t_plan;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic lower);
        logic [7:0] c;
        c = DIGIT_TAB[(4'd15 - nib) * 8 +: 8];
        return lower ? (c | CH_LOWER) : c;
    endfunction

endpackage

// ===== rtl/i2a_bcd.sv =====
module i2a_bcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [i2a_pkg::VAL_W-1:0]  i_bin,
    output logic                       o_done,
    output i2a_pkg::t_digits           o_bcd
);

    localparam int CNT_W = $clog2(i2a_pkg::VAL_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [i2a_pkg::VAL_W-1:0] r_bin;
    i2a_pkg::t_digits          r_bcd;
    i2a_pkg::t_digits          n_adj;
    logic [i2a_pkg::BCD_W-1:0] n_flat;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < i2a_pkg::BCD_DIGITS; d++) begin
            n_adj[d] = (r_bcd[d] >= 4'd5) ? (r_bcd[d] + 4'd3) : r_bcd[d];
        end
    end

    assign n_flat = n_adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(i2a_pkg::VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {n_flat[i2a_pkg::BCD_W-2:0], r_bin[i2a_pkg::VAL_W-1]};
            r_bin <= {r_bin[i2a_pkg::VAL_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/i2a_emit.sv =====
module i2a_emit #(
    parameter int MAX_WIDTH = i2a_pkg::MAX_WIDTH_DEF,
    localparam int PAD_W    = $clog2(MAX_WIDTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2a_pkg::t_plan     i_plan,
    input  logic [PAD_W-1:0]   i_pad,
    output logic               o_busy,
    output logic               o_strobe,
    output logic [7:0]         o_ch,
    output logic               o_last
);

    typedef enum logic [6:0] {
        E_IDLE  = 7'b0000001,
        E_BAD   = 7'b0000010,
        E_SIGN1 = 7'b0000100,
        E_PAD   = 7'b0001000,
        E_SIGN2 = 7'b0010000,
        E_DOT   = 7'b0100000,
        E_DIG   = 7'b1000000
    } t_estate;

    t_estate          r_state, n_state;
    logic [PAD_W-1:0] r_pad, n_pad;
    logic [3:0]       r_idx, n_idx;
    i2a_pkg::t_plan   r_plan;
    logic             r_strobe, n_strobe;
    logic             r_last, n_last;
    logic [7:0]       r_ch, n_ch;

    function automatic t_estate f_to_digits(input i2a_pkg::t_plan p);
        return (p.dot_en && (p.dot_pos == p.num_dig)) ? E_DOT : E_DIG;
    endfunction

    function automatic t_estate f_after_pad(input i2a_pkg::t_plan p);
        return (p.sign_en && !p.sign_first) ? E_SIGN2 : f_to_digits(p);
    endfunction

    function automatic t_estate f_after_sign1(input i2a_pkg::t_plan p,
                                              input logic [PAD_W-1:0] pad);
        return (pad != '0) ? E_PAD : f_after_pad(p);
    endfunction

    always_comb begin
        n_state  = r_state;
        n_pad    = r_pad;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_ch     = r_ch;
        case (r_state)
            E_IDLE: begin
                if (i_load) begin
                    n_pad = i_pad;
                    n_idx = i_plan.num_dig - 4'd1;
                    if (i_plan.bad) begin
                        n_state = E_BAD;
                    end else if (i_plan.sign_en && i_plan.sign_first) begin
                        n_state = E_SIGN1;
                    end else begin
                        n_state = f_after_sign1(i_plan, i_pad);
                    end
                end
            end
            E_BAD: begin
                n_strobe = 1'b1;
                n_ch     = i2a_pkg::CH_QUEST;
                n_last   = 1'b1;
                n_state  = E_IDLE;
            end
            E_SIGN1: begin
                n_strobe = 1'b1;
                n_ch     = r_plan.sign_ch;
                n_state  = f_after_sign1(r_plan, r_pad);
            end
            E_PAD: begin
                n_strobe = 1'b1;
                n_ch     = r_plan.fill_ch;
                n_pad    = r_pad - 1'b1;
                if (r_pad == PAD_W'(1)) begin
                    n_state = f_after_pad(r_plan);
                end
            end
            E_SIGN2: begin
                n_strobe = 1'b1;
                n_ch     = r_plan.sign_ch;
                n_state  = f_to_digits(r_plan);
            end
            E_DOT: begin
                n_strobe = 1'b1;
                n_ch     = i2a_pkg::CH_DOT;
                n_state  = E_DIG;
            end
            E_DIG: begin
                n_strobe = 1'b1;
                n_ch     = i2a_pkg::digit_char(r_plan.digits[r_idx], r_plan.lower);
                if (r_idx == 4'd0) begin
                    n_last  = 1'b1;
                    n_state = E_IDLE;
                end else begin
                    n_idx = r_idx - 4'd1;
                    // the point goes in front of digit dot_pos - 1
                    n_state = (r_plan.dot_en && (r_idx == r_plan.dot_pos)) ? E_DOT : E_DIG;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_pad    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pad    <= n_pad;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
        if (i_load && (r_state == E_IDLE)) begin
            r_plan <= i_plan;
        end
    end

    assign o_busy   = (r_state != E_IDLE);
    assign o_strobe = r_strobe;
    assign o_ch     = r_ch;
    assign o_last   = r_last;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// printf-style integer formatter: one request per start, written out as ASCII characters,
// one per cycle on o_ch with o_strobe, o_last on the final one. The receiver cannot stall,
// so every character is shown for exactly one cycle. Decimal kinds run a serial binary to
// BCD converter (one bit per cycle) before the characters start; hex and unknown kinds go
// straight to planning. A request writes at most MAX_WIDTH characters, or twelve where
// MAX_WIDTH is smaller. busy stays high until the last character is on the port.
module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH = i2a_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [i2a_pkg::CMD_W-1:0]        i_cmd,
    input  logic [i2a_pkg::VAL_W-1:0]        i_value,
    input  logic [i2a_pkg::FW_W-1:0]         i_field_width,
    input  logic signed [i2a_pkg::PREC_W-1:0] i_precision,
    input  logic                             i_zero_fill,
    input  logic                             i_force_plus,
    output logic                             o_strobe,
    output logic [7:0]                       o_ch,
    output logic                             o_last
);

    localparam int PAD_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PLAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [i2a_pkg::CMD_W-1:0]          r_cmd;
    logic [i2a_pkg::VAL_W-1:0]          r_mag;
    logic [PAD_W-1:0]                   r_w;
    logic [i2a_pkg::PREC_W-1:0]         r_prec;
    logic                               r_zfill;
    logic                               r_sign_en;
    logic [7:0]                         r_sign_ch;

    logic                               accept;
    logic                               in_signed;
    logic                               in_neg;
    logic                               in_dec;
    logic [i2a_pkg::VAL_W-1:0]          in_mag;
    logic [i2a_pkg::FW_W:0]             fw_ext;
    logic [PAD_W-1:0]                   w_sat;

    logic                               bcd_done;
    i2a_pkg::t_digits                   bcd;
    logic                               emit_busy;

    logic                               is_hex;
    logic                               is_fix;
    logic                               no_prec;
    logic [4:0]                         p;
    i2a_pkg::t_digits                   dig;
    logic [3:0]                         nat;
    logic [5:0]                         lim;
    logic                               forced;
    logic [5:0]                         dt;
    logic [3:0]                         dmax;
    logic [3:0]                         ndig;
    logic                               reserve;
    logic [3:0]                         sub;
    logic [PAD_W-1:0]                   pad;
    i2a_pkg::t_plan                     plan;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        in_signed = (i_cmd == i2a_pkg::CMD_SDEC) || (i_cmd == i2a_pkg::CMD_FIX);
        in_dec    = in_signed || (i_cmd == i2a_pkg::CMD_UDEC);
        in_neg    = in_signed && i_value[i2a_pkg::VAL_W-1];
        in_mag    = in_neg ? (i2a_pkg::VAL_W'(0) - i_value) : i_value;
        fw_ext    = {1'b0, i_field_width};
        w_sat     = (fw_ext > (i2a_pkg::FW_W + 1)'(MAX_WIDTH)) ? PAD_W'(MAX_WIDTH)
                                                               : PAD_W'(fw_ext);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = in_dec ? S_CONV : S_PLAN;
                end
            end
            S_CONV: begin
                if (bcd_done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_mag     <= in_mag;
            r_w       <= w_sat;
            r_prec    <= unsigned'(i_precision);
            r_zfill   <= i_zero_fill;
            r_sign_en <= in_signed && (i_value[i2a_pkg::VAL_W-1] || i_force_plus);
            r_sign_ch <= in_neg ? i2a_pkg::CH_MINUS : i2a_pkg::CH_PLUS;
        end
    end

    i2a_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && in_dec),
        .i_bin   (in_mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    // digit count, padding and point position, worked out once the digits are known
    always_comb begin
        is_hex  = (r_cmd == i2a_pkg::CMD_LHEX) || (r_cmd == i2a_pkg::CMD_UHEX);
        is_fix  = (r_cmd == i2a_pkg::CMD_FIX);
        no_prec = r_prec[i2a_pkg::PREC_W-1];
        p       = r_prec[4:0];
        dig     = is_hex ? i2a_pkg::t_digits'({8'd0, r_mag}) : bcd;

        nat = 4'd1;
        for (int i = 1; i < i2a_pkg::BCD_DIGITS; i++) begin
            if (dig[i] != 4'd0) begin
                nat = 4'(i + 1);
            end
        end

        if (no_prec) begin
            lim = 6'd0;
        end else if (is_fix) begin
            lim = (p == 5'd0) ? 6'd0 : ({1'b0, p} + 6'd1);
        end else begin
            lim = {1'b0, p};
        end

        // a forced count above nine still applies once the natural digits bring it in range
        forced = (lim >= 6'd2) && (({2'b00, nat} + 6'd8) >= lim);
        dt     = (forced && (lim > {2'b00, nat})) ? lim : {2'b00, nat};
        dmax   = is_hex ? 4'(i2a_pkg::HEX_DIGITS) : 4'(i2a_pkg::BCD_DIGITS);
        ndig   = (dt > {2'b00, dmax}) ? dmax : dt[3:0];

        reserve = is_fix && !no_prec && (p != 5'd0);
        sub     = ndig + {3'd0, reserve} + {3'd0, r_sign_en};
        pad     = (r_w > PAD_W'(sub)) ? (r_w - PAD_W'(sub)) : '0;

        plan.bad        = (r_cmd > i2a_pkg::CMD_FIX);
        plan.sign_en    = r_sign_en;
        plan.sign_first = r_zfill;
        plan.sign_ch    = r_sign_ch;
        plan.fill_ch    = r_zfill ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
        plan.lower      = (r_cmd == i2a_pkg::CMD_LHEX);
        plan.num_dig    = ndig;
        plan.dot_en     = reserve && (p <= {1'b0, ndig});
        plan.dot_pos    = p[3:0];
        plan.digits     = dig;
    end

    i2a_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_PLAN),
        .i_plan   (plan),
        .i_pad    (pad),
        .o_busy   (emit_busy),
        .o_strobe (o_strobe),
        .o_ch     (o_ch),
        .o_last   (o_last)
    );

endmodule

// ===== rtl/i2a_checker.sv =====
module i2a_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_last
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // only the final character may appear once busy has dropped
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final character while idle");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("character directly after final character");

    // busy drops in the cycle right after the final character
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_strobe && o_last))
        else $error("busy dropped without final character");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last marker without strobe");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_last   (o_last)
);
